FILE: sv/rgb565_bmp_frame_encoder_core_assert.svh
// Assertion macros shared by the encoder modules.
`ifndef RGB565_BMP_FRAME_ENCODER_CORE_ASSERT_SVH
`define RGB565_BMP_FRAME_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RGBBMP_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define RGBBMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/rgbbmp_pkg.sv
package rgbbmp_pkg;

    localparam int DEF_MAX_DIM = 1024;

    // Field widths of the configuration and the size fields of the header.
    localparam int DIM_W    = 11;
    localparam int STRIDE_W = 13;
    localparam int SIZE_W   = 24;
    localparam int FILE_W   = 25;
    localparam int IDX_W    = 6;
    localparam int HDR_LEN  = 54;

    localparam logic [7:0] HDR_INFO_SIZE = 8'd40;
    localparam logic [7:0] HDR_PLANES    = 8'd1;
    localparam logic [7:0] HDR_BPP       = 8'd24;
    localparam logic [7:0] CHAR_B        = 8'h42;
    localparam logic [7:0] CHAR_M        = 8'h4D;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg;

    // One item's worth of output, as handed from the front end to the serializer.
    typedef struct packed {
        logic              is_hdr;
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic [1:0]        pad;
        logic              frame_end;
        logic [FILE_W-1:0] file_len;
        logic [SIZE_W-1:0] data_size;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } t_item;

    // round(v*255/31) for v in 0..31
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [13:0] p;
        p = 14'(v) * 14'd527 + 14'd23;
        return p[13:6];
    endfunction

    // round(v*255/63) for v in 0..63
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [13:0] p;
        p = 14'(v) * 14'd259 + 14'd33;
        return p[13:6];
    endfunction

    // Header byte at a given offset; multi-byte fields are little endian.
    function automatic logic [7:0] hdr_byte(input t_item it, input logic [IDX_W-1:0] idx);
        logic [31:0] fs;
        logic [31:0] ds;
        logic [31:0] wd;
        logic [31:0] ht;
        logic [7:0]  b;
        fs = 32'(it.file_len);
        ds = 32'(it.data_size);
        wd = 32'(it.width);
        ht = 32'(it.height);
        unique case (idx)
            6'd0:    b = CHAR_B;
            6'd1:    b = CHAR_M;
            6'd2:    b = fs[7:0];
            6'd3:    b = fs[15:8];
            6'd4:    b = fs[23:16];
            6'd5:    b = fs[31:24];
            6'd10:   b = 8'(HDR_LEN);
            6'd14:   b = HDR_INFO_SIZE;
            6'd18:   b = wd[7:0];
            6'd19:   b = wd[15:8];
            6'd20:   b = wd[23:16];
            6'd21:   b = wd[31:24];
            6'd22:   b = ht[7:0];
            6'd23:   b = ht[15:8];
            6'd24:   b = ht[23:16];
            6'd25:   b = ht[31:24];
            6'd26:   b = HDR_PLANES;
            6'd28:   b = HDR_BPP;
            6'd34:   b = ds[7:0];
            6'd35:   b = ds[15:8];
            6'd36:   b = ds[23:16];
            6'd37:   b = ds[31:24];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/rgbbmp_in_if.sv
interface rgbbmp_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] pixel;

    modport source (output valid, output command, output pixel, input ready);
    modport sink   (input valid, input command, input pixel, output ready);
endinterface

FILE: sv/rgbbmp_out_if.sv
interface rgbbmp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_done;

    modport source (output valid, output out_byte, output last_of_run, output frame_done,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input frame_done,
                    output ready);
endinterface

FILE: sv/rgbbmp_ser.sv
`include "rgb565_bmp_frame_encoder_core_assert.svh"

module rgbbmp_ser
    import rgbbmp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_item i_item,
    output logic  o_free,
    rgbbmp_out_if.source o_out
);

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_item            r_item;

    logic [IDX_W-1:0] w_last_idx;
    logic             w_last;
    logic             w_take;

    always_comb begin
        w_last_idx = r_item.is_hdr ? IDX_W'(HDR_LEN - 1) : IDX_W'(2) + IDX_W'(r_item.pad);
        w_last     = (r_idx == w_last_idx);
        w_take     = r_busy && o_out.ready;
        // free once the final byte of the held item leaves
        o_free     = !r_busy || (w_take && w_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        o_out.valid       = r_busy;
        o_out.last_of_run = w_last;
        o_out.frame_done  = w_last && r_item.frame_end && !r_item.is_hdr;
        if (r_item.is_hdr) begin
            o_out.out_byte = hdr_byte(r_item, r_idx);
        end else begin
            unique case (r_idx)
                6'd0:    o_out.out_byte = r_item.blue;
                6'd1:    o_out.out_byte = r_item.green;
                6'd2:    o_out.out_byte = r_item.red;
                default: o_out.out_byte = 8'd0;
            endcase
        end
    end

    `RGBBMP_ASSERT(a_idx_in_range, i_clk, i_rst_n, r_busy, r_idx <= w_last_idx)
    `RGBBMP_ASSERT(a_load_when_free, i_clk, i_rst_n, i_load, o_free)
    `RGBBMP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_busy && !o_out.ready && !i_load,
                        r_busy && $stable(r_idx))
    `RGBBMP_ASSERT(a_done_on_pixel_last, i_clk, i_rst_n, r_busy && o_out.frame_done,
                   w_last && !r_item.is_hdr)

endmodule

FILE: sv/rgb565_bmp_frame_encoder_core.sv
// Streams a 24-bit BMP file from RGB565 pixels, one byte per cycle while the output
// port is ready. A start item (command 0) emits the 54-byte header for the
// configured width and height and opens a frame; a bad size emits nothing and
// closes the frame. Each pixel item (command 1) emits blue, green, red expanded to
// 8 bits, plus 0 to 3 zero pad bytes at a row end; pixels go bottom row first. A
// pixel with no open frame emits nothing. The byte-wide output port sets the pace;
// the next item is accepted in the same cycle the final byte of the previous one
// is taken, and an item that emits nothing is absorbed without loading the
// serializer.
`include "rgb565_bmp_frame_encoder_core_assert.svh"

module rgb565_bmp_frame_encoder_core
    import rgbbmp_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data,
    rgbbmp_in_if.sink        i_in,
    rgbbmp_out_if.source     o_out
);

    localparam int CLOG_DIM = $clog2(MAX_DIM + 1);
    localparam int CMP_W    = (CLOG_DIM > DIM_W) ? CLOG_DIM : DIM_W;
    localparam logic [CMP_W-1:0] MAX_V   = CMP_W'(MAX_DIM);
    localparam logic [1:0]       MAX_PAD = 2'(MAX_DIM % 4);

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             r_open;
    logic [DIM_W-1:0] r_col;
    logic [DIM_W-1:0] r_row;

    logic             n_open;
    logic [DIM_W-1:0] n_col;
    logic [DIM_W-1:0] n_row;

    logic                w_free;
    logic                w_accept;
    logic                w_load;
    t_item               w_item;
    logic                w_bad;
    logic [STRIDE_W-1:0] w_w3;
    logic [STRIDE_W-1:0] w_stride;
    logic [SIZE_W-1:0]   w_data;
    logic [DIM_W-1:0]    w_col_inc;
    logic [DIM_W-1:0]    w_row_inc;

    assign i_in.ready = w_free;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(466);
            r_height <= DIM_W'(466);
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        w_bad = (r_width == '0) || (r_height == '0) ||
                (CMP_W'(r_width) > MAX_V) || (CMP_W'(r_height) > MAX_V);
        // stride = 3*w rounded up to a multiple of four
        w_w3     = STRIDE_W'({r_width, 1'b0}) + STRIDE_W'(r_width) + STRIDE_W'(3);
        w_stride = {w_w3[STRIDE_W-1:2], 2'b00};
        w_data   = SIZE_W'(w_stride) * SIZE_W'(r_height);

        w_col_inc = r_col + DIM_W'(1);
        w_row_inc = r_row + DIM_W'(1);

        w_item.is_hdr    = 1'b0;
        w_item.blue      = expand5(i_in.pixel[4:0]);
        w_item.green     = expand6(i_in.pixel[10:5]);
        w_item.red       = expand5(i_in.pixel[15:11]);
        w_item.pad       = 2'd0;
        w_item.frame_end = 1'b0;
        w_item.file_len  = FILE_W'(w_data) + FILE_W'(HDR_LEN);
        w_item.data_size = w_data;
        w_item.width     = r_width;
        w_item.height    = r_height;

        n_open = r_open;
        n_col  = r_col;
        n_row  = r_row;
        w_load = 1'b0;

        if (w_accept) begin
            unique case (t_cmd'(i_in.command))
                CMD_START: begin
                    if (w_bad) begin
                        n_open = 1'b0;
                    end else begin
                        w_load        = 1'b1;
                        w_item.is_hdr = 1'b1;
                        n_open        = 1'b1;
                        n_col         = '0;
                        n_row         = '0;
                    end
                end
                CMD_PIXEL: begin
                    if (r_open) begin
                        w_load = 1'b1;
                        if (w_col_inc >= r_width) begin
                            // row end: pad follows the clamped width
                            w_item.pad = (CMP_W'(r_width) > MAX_V) ? MAX_PAD : r_width[1:0];
                            n_col      = '0;
                            if (w_row_inc >= r_height) begin
                                w_item.frame_end = 1'b1;
                                n_open           = 1'b0;
                                n_row            = '0;
                            end else begin
                                n_row = w_row_inc;
                            end
                        end else begin
                            n_col = w_col_inc;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_col  <= '0;
            r_row  <= '0;
        end else begin
            r_open <= n_open;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

    rgbbmp_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_item  (w_item),
        .o_free  (w_free),
        .o_out   (o_out)
    );

    `RGBBMP_ASSERT_NEXT(a_hdr_opens_frame, i_clk, i_rst_n, w_load && w_item.is_hdr,
                        r_open && (r_col == '0) && (r_row == '0))
    `RGBBMP_ASSERT(a_pixel_needs_frame, i_clk, i_rst_n, w_load && !w_item.is_hdr, r_open)

endmodule
